// ===== src/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam int FIELD_BITS = 31;
  localparam int WIDE_BITS  = 64;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture operands, form products
    logic prep;      // form unreduced terms and check faults
    logic gcd_init;  // seed gcd with current terms
    logic gcd_step;  // one binary gcd iteration
    logic div_init;  // start dividing terms by gcd
    logic div_step;  // one quotient bit for both terms
    logic shift;     // halve both terms; limit/1 if den would be 0
    logic zero_fix;  // numerator zero gives 0/1
  } rau_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fault;
    logic num_zero;
    logic gcd_done;
    logic div_done;
    logic over;      // a term exceeds the limit
  } rau_sts_t;

endpackage

// ===== src/rau_datapath.sv =====
// datapath: products, binary gcd, restoring division and rounding shifts
module rau_datapath #(
  parameter int MAG_BITS = 31
) (
  input  logic                 clk,
  input  rau_pkg::rau_cmd_t    cmd,
  input  logic [1:0]           action,
  input  logic [30:0]          a_num,
  input  logic [30:0]          a_den,
  input  logic                 a_neg,
  input  logic [30:0]          b_num,
  input  logic [30:0]          b_den,
  input  logic                 b_neg,
  output rau_pkg::rau_sts_t    sts,
  output logic [30:0]          res_num,
  output logic [30:0]          res_den,
  output logic                 res_neg
);

  localparam logic [63:0] LIMIT = (64'd1 << MAG_BITS) - 64'd1;

  logic [63:0] p1_r, p2_r, pd_r, pm_r, pq_r;
  logic [1:0]  act_r;
  logic        as_r, bs_r, bad_r;
  logic [63:0] n_r, d_r;
  logic        neg_r, fault_r;
  logic [63:0] gx_r, gy_r;
  logic [6:0]  gk_r;
  logic [63:0] qn_r, qd_r, rn_r, rd_r;
  logic [6:0]  dc_r;

  // sign resolution for add and subtract; numerator and sign for all actions
  logic        use_sub, flip, swap;
  logic [63:0] s1, s2, n_nxt;
  logic        neg_nxt;

  always_comb begin
    use_sub = 1'b0;
    flip    = 1'b0;
    swap    = 1'b0;
    unique case (act_r)
      rau_pkg::ACT_ADD: begin
        if (as_r && bs_r) flip = 1'b1;
        else if (as_r) begin use_sub = 1'b1; swap = 1'b1; end
        else if (bs_r) use_sub = 1'b1;
      end
      rau_pkg::ACT_SUB: begin
        if (as_r && bs_r) begin use_sub = 1'b1; flip = 1'b1; end
        else if (as_r) flip = 1'b1;
        else if (!bs_r) use_sub = 1'b1;
      end
      default: ;
    endcase
    s1 = swap ? p2_r : p1_r;
    s2 = swap ? p1_r : p2_r;
    if (act_r == rau_pkg::ACT_MUL) begin
      n_nxt = pm_r; neg_nxt = as_r ^ bs_r;
    end else if (act_r == rau_pkg::ACT_DIV) begin
      n_nxt = p1_r; neg_nxt = as_r ^ bs_r;
    end else if (use_sub) begin
      if (s1 < s2) begin n_nxt = s2 - s1; neg_nxt = 1'b1 ^ flip; end
      else begin n_nxt = s1 - s2; neg_nxt = flip; end
    end else begin
      n_nxt = s1 + s2; neg_nxt = flip;
    end
  end

  logic [63:0] d_sel;
  assign d_sel = (act_r == rau_pkg::ACT_DIV) ? pq_r : pd_r;

  // one binary gcd step: strip common twos, then subtract
  logic [63:0] gx_nxt, gy_nxt, gdif;
  logic [6:0]  gk_nxt;
  always_comb begin
    gx_nxt = gx_r; gy_nxt = gy_r; gk_nxt = gk_r;
    gdif = (gx_r > gy_r) ? gx_r - gy_r : gy_r - gx_r;
    if (!gx_r[0] && !gy_r[0]) begin
      gx_nxt = gx_r >> 1; gy_nxt = gy_r >> 1; gk_nxt = gk_r + 7'd1;
    end else if (!gx_r[0]) gx_nxt = gx_r >> 1;
    else if (!gy_r[0]) gy_nxt = gy_r >> 1;
    else if (gx_r > gy_r) gx_nxt = gdif;
    else gy_nxt = gdif;
  end
  logic [63:0] g_full;
  assign g_full = gx_r << gk_r[5:0];

  // restoring division of both terms by g, one bit per step
  logic [64:0] tn, td;
  assign tn = {rn_r, qn_r[63]};
  assign td = {rd_r, qd_r[63]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action; as_r <= a_neg; bs_r <= b_neg;
      bad_r <= (a_den == '0) || (b_den == '0);
      p1_r <= {33'd0, a_num} * {33'd0, b_den};
      p2_r <= {33'd0, b_num} * {33'd0, a_den};
      pd_r <= {33'd0, a_den} * {33'd0, b_den};
      pm_r <= {33'd0, a_num} * {33'd0, b_num};
      pq_r <= {33'd0, a_den} * {33'd0, b_num};
    end
    if (cmd.prep) begin
      n_r <= n_nxt; d_r <= d_sel; neg_r <= neg_nxt;
      fault_r <= bad_r || (d_sel == '0 && n_nxt != '0);
    end
    if (cmd.gcd_init) begin
      gx_r <= n_r; gy_r <= d_r; gk_r <= '0;
    end else if (cmd.gcd_step) begin
      gx_r <= gx_nxt; gy_r <= gy_nxt; gk_r <= gk_nxt;
    end
    if (cmd.div_init) begin
      qn_r <= n_r; qd_r <= d_r; rn_r <= '0; rd_r <= '0; dc_r <= '0;
      gx_r <= g_full;
    end else if (cmd.div_step) begin
      qn_r <= {qn_r[62:0], tn >= {1'b0, gx_r}};
      qd_r <= {qd_r[62:0], td >= {1'b0, gx_r}};
      rn_r <= (tn >= {1'b0, gx_r}) ? 64'(tn - {1'b0, gx_r}) : tn[63:0];
      rd_r <= (td >= {1'b0, gx_r}) ? 64'(td - {1'b0, gx_r}) : td[63:0];
      dc_r <= dc_r + 7'd1;
      if (dc_r == 7'd63) begin
        n_r <= {qn_r[62:0], tn >= {1'b0, gx_r}};
        d_r <= {qd_r[62:0], td >= {1'b0, gx_r}};
      end
    end
    if (cmd.shift) begin
      if ((d_r >> 1) == '0) begin n_r <= LIMIT; d_r <= 64'd1; end
      else begin n_r <= n_r >> 1; d_r <= d_r >> 1; end
    end
    if (cmd.zero_fix) d_r <= 64'd1;
  end

  assign sts.fault    = fault_r;
  assign sts.num_zero = (n_r == '0);
  assign sts.gcd_done = (gy_r == '0) || (gx_r == gy_r);
  assign sts.div_done = (dc_r == 7'd64);
  assign sts.over     = (n_r > LIMIT) || (d_r > LIMIT);

  assign res_num = fault_r ? '0 : n_r[30:0];
  assign res_den = fault_r ? '0 : d_r[30:0];
  assign res_neg = fault_r ? 1'b0 : neg_r;

endmodule

// ===== src/rau_ctrl.sv =====
// controller state machine sequencing the datapath
module rau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               taken,
  input  rau_pkg::rau_sts_t  sts,
  output rau_pkg::rau_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_GCD  = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_OVR  = 4'd5;
  localparam logic [3:0] S_OUT  = 4'd6;
  localparam logic [3:0] S_GFIX = 4'd7;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: if (start) begin cmd.load = 1'b1; state_nxt = S_PREP; end
      S_PREP: begin cmd.prep = 1'b1; state_nxt = S_CHK; end
      S_CHK: begin
        if (sts.fault) state_nxt = S_OUT;
        else if (sts.num_zero) begin cmd.zero_fix = 1'b1; state_nxt = S_OVR; end
        else begin cmd.gcd_init = 1'b1; state_nxt = S_GCD; end
      end
      S_GCD: begin
        if (sts.gcd_done) state_nxt = S_GFIX;
        else cmd.gcd_step = 1'b1;
      end
      // gy zero means gx, shifted left by gk, holds the gcd; equal means gx too
      S_GFIX: begin cmd.div_init = 1'b1; state_nxt = S_DIV; end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_OVR;
        else cmd.div_step = 1'b1;
      end
      S_OVR: begin
        if (sts.over) begin cmd.shift = 1'b1; state_nxt = S_CHK; end
        else state_nxt = S_OUT;
      end
      S_OUT: if (taken) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_OUT);

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
    else $error("done outside busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    done && !taken |=> done) else $error("result dropped");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_PREP) else $error("bad start");

endmodule

// ===== src/rational_arithmetic_unit_top.sv =====
// top level of the rational arithmetic unit
// usage:
//   input beats carry two sign-magnitude fractions and an action code
//   (0 add, 1 subtract, 2 multiply, 3 divide); one result beat follows
//   each input beat with the reduced fraction and a fault flag.
//   one item is processed at a time: in_tready is high only when idle.
// sequence:
//   on a fault the result goes straight to out_tvalid, and a zero
//   numerator is set to 0/1 first; otherwise one reduction pass runs the
//   binary gcd steps and then the bit-serial divider. each rounding
//   shift, needed for wide products, adds another pass. the next beat is
//   accepted in the cycle after the result beat leaves.
// reset:
//   rst_n low returns the controller to idle; any item in flight is lost.
// stall:
//   the result is held on out_tdata until out_tready; no new beat is
//   accepted while a result waits.
module rational_arithmetic_unit_top #(
  parameter int MAG_BITS = 31
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action[1:0], a_numerator[32:2], a_denominator[63:33], a_negative[64],
  // b_numerator[95:65], b_denominator[126:96], b_negative[127]
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_numerator[30:0], result_denominator[61:31], result_negative[62],
  // fault[63]
  output logic [63:0]  out_tdata
);

  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;
  logic busy, done;
  logic [30:0] rn, rd;
  logic rneg;

  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_tvalid),
    .busy  (busy),
    .done  (done),
    .taken (out_tready),
    .sts   (sts),
    .cmd   (cmd)
  );

  rau_datapath #(.MAG_BITS(MAG_BITS)) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .action  (in_tdata[1:0]),
    .a_num   (in_tdata[32:2]),
    .a_den   (in_tdata[63:33]),
    .a_neg   (in_tdata[64]),
    .b_num   (in_tdata[95:65]),
    .b_den   (in_tdata[126:96]),
    .b_neg   (in_tdata[127]),
    .sts     (sts),
    .res_num (rn),
    .res_den (rd),
    .res_neg (rneg)
  );

  assign in_tready  = !busy;
  assign out_tvalid = done;
  assign out_tdata  = {sts.fault, rneg, rd, rn};

endmodule

// ===== sim/rational_arithmetic_unit_top_tb.sv =====
// testbench for the rational arithmetic unit: predicted fractions checked beat by beat
module rational_arithmetic_unit_top_tb;

  localparam logic [63:0] LIMIT = 64'h7FFF_FFFF;

  // highest field first, matching out_tdata
  typedef struct packed {
    logic        fault;
    logic        neg;
    logic [30:0] den;
    logic [30:0] num;
  } frac_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // action, a_numerator, a_denominator, a_negative, b_numerator, b_denominator, b_negative
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // result_numerator, result_denominator, result_negative, fault
  logic [63:0]  out_tdata;

  frac_res_t expected_q[$];
  int        err_count = 0;
  int        sent_count = 0;
  int        got_count = 0;
  int        idle_pct = 7;     // chance of an idle cycle, per hundred
  bit        hold_off = 1'b0;  // long receiver stall

  rational_arithmetic_unit_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 64'd0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // lowest terms; zero numerator gives 0/1
  function automatic void lowest(inout logic [63:0] n, inout logic [63:0] d);
    logic [63:0] g;
    if (n == 64'd0) begin
      d = 64'd1;
    end else begin
      g = gcd_of(n, d);
      if (g != 64'd0) begin
        n = n / g;
        d = d / g;
      end
    end
  endfunction

  function automatic frac_res_t predict_fraction(logic [1:0] act,
      logic [30:0] an31, logic [30:0] ad31, logic as_,
      logic [30:0] bn31, logic [30:0] bd31, logic bs_);
    logic [63:0] an, ad, bn, bd, p1, p2, t, n, d;
    logic neg, flip, use_sub;
    frac_res_t r;
    an = 64'(an31); ad = 64'(ad31); bn = 64'(bn31); bd = 64'(bd31);
    p1 = an * bd;
    p2 = bn * ad;
    d = ad * bd;
    n = 64'd0;
    neg = 1'b0; flip = 1'b0; use_sub = 1'b0;
    if (act == rau_pkg::ACT_ADD) begin
      if (as_ && bs_) flip = 1'b1;
      else if (as_) begin
        use_sub = 1'b1; t = p1; p1 = p2; p2 = t;
      end else if (bs_) use_sub = 1'b1;
    end else if (act == rau_pkg::ACT_SUB) begin
      if (as_ && bs_) begin use_sub = 1'b1; flip = 1'b1; end
      else if (as_) flip = 1'b1;
      else if (!bs_) use_sub = 1'b1;
    end
    if (act == rau_pkg::ACT_ADD || act == rau_pkg::ACT_SUB) begin
      if (use_sub) begin
        if (p1 < p2) begin n = p2 - p1; neg = 1'b1; end
        else n = p1 - p2;
      end else begin
        n = p1 + p2;
      end
      if (flip) neg = !neg;
    end else if (act == rau_pkg::ACT_MUL) begin
      n = an * bn;
      neg = as_ != bs_;
    end else begin
      n = an * bd;
      d = ad * bn;
      neg = as_ != bs_;
    end
    r = '0;
    if (ad == 64'd0 || bd == 64'd0 || (d == 64'd0 && n != 64'd0)) begin
      r.fault = 1'b1;
      return r;
    end
    lowest(n, d);
    while (n > LIMIT || d > LIMIT) begin
      n = n >> 1;
      d = d >> 1;
      if (d == 64'd0) begin
        n = LIMIT;
        d = 64'd1;
      end
      lowest(n, d);
    end
    r.num = n[30:0];
    r.den = d[30:0];
    r.neg = neg;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on beat %0d: %s got %0h want %0h", got_count, what, got, want);
    err_count++;
  endtask

  // one input beat; the expectation is queued when it is accepted
  task automatic send_fraction(logic [1:0] act, logic [30:0] an, logic [30:0] ad, logic as_,
      logic [30:0] bn, logic [30:0] bd, logic bs_);
    bit ready_seen;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {bs_, bd, bn, as_, ad, an, act};
    // ready only moves at rising edges, so mid-cycle it shows the coming edge
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    expected_q.push_back(predict_fraction(act, an, ad, as_, bn, bd, bs_));
    sent_count++;
  endtask

  // receiver readiness
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    frac_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      got_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata, 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.num !== want.num)
          report_mismatch("numerator", 64'(got.num), 64'(want.num));
        if (got.den !== want.den)
          report_mismatch("denominator", 64'(got.den), 64'(want.den));
        if (got.neg !== want.neg)
          report_mismatch("sign", 64'(got.neg), 64'(want.neg));
        if (got.fault !== want.fault)
          report_mismatch("fault", 64'(got.fault), 64'(want.fault));
      end
    end
  end

  function automatic logic [30:0] rand_mag();
    case ($urandom_range(5))
      0: return 31'($urandom_range(15));
      1: return 31'($urandom_range(255));
      2: return 31'h7FFF_FFFF - 31'($urandom_range(3));
      3: return 31'($urandom_range(65535));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    if ($urandom_range(49) == 0) return 31'd0;
    return ($urandom_range(3) == 0) ? 31'd1 : rand_mag();
  endfunction

  task automatic test_directed();
    logic [1:0] op;
    for (int i = 0; i < 4; i++) begin
      op = 2'(i);
      send_fraction(op, 31'd1, 31'd2, 1'b0, 31'd1, 31'd3, 1'b0);
      send_fraction(op, 31'h7FFF_FFFF, 31'd1, 1'b1, 31'h7FFF_FFFF, 31'd1, 1'b0);
      send_fraction(op, 31'd5, 31'd7, 1'b1, 31'd5, 31'd7, 1'b1);
    end
    // zero operand denominators
    send_fraction(rau_pkg::ACT_ADD, 31'd3, 31'd0, 1'b0, 31'd1, 31'd1, 1'b0);
    send_fraction(rau_pkg::ACT_MUL, 31'd3, 31'd1, 1'b0, 31'd1, 31'd0, 1'b1);
    // division by zero, and zero over zero
    send_fraction(rau_pkg::ACT_DIV, 31'd3, 31'd4, 1'b0, 31'd0, 31'd9, 1'b0);
    send_fraction(rau_pkg::ACT_DIV, 31'd0, 31'd4, 1'b1, 31'd0, 31'd9, 1'b0);
    // equal magnitudes give positive zero, zero times negative
    send_fraction(rau_pkg::ACT_SUB, 31'd4, 31'd6, 1'b0, 31'd2, 31'd3, 1'b0);
    send_fraction(rau_pkg::ACT_MUL, 31'd0, 31'd6, 1'b1, 31'd2, 31'd3, 1'b0);
    // denominator shifts away to zero
    send_fraction(rau_pkg::ACT_DIV, 31'h7FFF_FFFF, 31'd1, 1'b0, 31'd1, 31'h7FFF_FFFF, 1'b0);
    // large products that need rounding
    send_fraction(rau_pkg::ACT_ADD, 31'h7FFF_FFFE, 31'h7FFF_FFFD, 1'b0,
                  31'h7FFF_FFFB, 31'h7FFF_FFF9, 1'b0);
    send_fraction(rau_pkg::ACT_MUL, 31'h7FFF_FFFF, 31'd3, 1'b0, 31'h7FFF_FFFD, 31'd7, 1'b1);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_fraction(2'($urandom), rand_mag(), rand_den(), 1'($urandom),
                    rand_mag(), rand_den(), 1'($urandom));
  endtask

  // receiver stalls for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    idle_pct = 0;
    test_random(200);
    idle_pct = 7;
    test_backpressure();
    test_random(580);
    drain();
    $display("sent %0d beats of all four operations, checked %0d results", sent_count, got_count);
    $display("covered zero denominators, division by zero, rounding and a long output stall");
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("rational_arithmetic_unit_top_tb: clean");
    end else begin
      $display("rational_arithmetic_unit_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("timeout after %0d of %0d results", got_count, sent_count);
    $display("rational_arithmetic_unit_top_tb: errors");
    $finish;
  end

endmodule
